>>> sv/brf_pkg.sv
package brf_pkg;

    localparam int DATA_W     = 32;
    localparam int NUM_REGS   = 16;
    localparam int SLOTS_PER_BANK = 8;

    // Processor modes
    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    // Bank numbers
    localparam logic [2:0] BANK_USR = 3'd0;
    localparam logic [2:0] BANK_FIQ = 3'd1;
    localparam logic [2:0] BANK_IRQ = 3'd2;
    localparam logic [2:0] BANK_SVC = 3'd3;
    localparam logic [2:0] BANK_ABT = 3'd4;
    localparam logic [2:0] BANK_UND = 3'd5;

    // Saved status write masks
    localparam logic [DATA_W-1:0] SPSR_MASK_OLD = 32'hF000_00FF;
    localparam logic [DATA_W-1:0] SPSR_MASK_NEW = 32'hF800_00FF;

    // Slots of a bank in the banked store
    localparam logic [2:0] SLOT_R8  = 3'd0;
    localparam logic [2:0] SLOT_R12 = 3'd4;
    localparam logic [2:0] SLOT_R13 = 3'd6;
    localparam logic [2:0] SLOT_R14 = 3'd7;

    localparam logic [3:0] REG_R13 = 4'd13;
    localparam logic [3:0] REG_R14 = 4'd14;
    localparam logic [3:0] REG_PC  = 4'd15;

    typedef enum logic [2:0] {
        OP_RDREG        = 3'd0,
        OP_WRREG        = 3'd1,
        OP_RDCPSR       = 3'd2,
        OP_WRCPSR       = 3'd3,
        OP_RDSPSR       = 3'd4,
        OP_WRSPSR       = 3'd5,
        OP_CPSR_TO_SPSR = 3'd6,
        OP_SPSR_TO_CPSR = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWAP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] idx;
    } bank_sel_t;

    // Map a mode field to its register bank
    function automatic bank_sel_t bank_of(logic [4:0] mode);
        bank_sel_t sel;
        sel.ok  = 1'b1;
        sel.idx = BANK_USR;
        case (mode)
            MODE_USR, MODE_SYS: sel.idx = BANK_USR;
            MODE_FIQ:           sel.idx = BANK_FIQ;
            MODE_IRQ:           sel.idx = BANK_IRQ;
            MODE_SVC:           sel.idx = BANK_SVC;
            MODE_ABT:           sel.idx = BANK_ABT;
            MODE_UND:           sel.idx = BANK_UND;
            default:            sel.ok  = 1'b0;
        endcase
        return sel;
    endfunction

    // Assemble the status word; Q shows only on the newer core
    function automatic logic [DATA_W-1:0] status_word(logic [4:0] mode, logic thumb,
                                                      logic [6:0] flags, logic core_kind);
        logic [DATA_W-1:0] v;
        v         = '0;
        v[4:0]    = mode;
        v[5]      = thumb;
        v[6]      = flags[0];
        v[7]      = flags[1];
        v[27]     = flags[2] & core_kind;
        v[31:28]  = flags[6:3];
        return v;
    endfunction

    // Visible register that a bank slot shadows
    function automatic logic [3:0] slot_to_reg(logic [2:0] slot);
        logic [3:0] r;
        if (slot == SLOT_R13) begin
            r = REG_R13;
        end
        else if (slot == SLOT_R14) begin
            r = REG_R14;
        end
        else begin
            r = {1'b1, slot};
        end
        return r;
    endfunction

endpackage

>>> sv/banked_register_file_psr.sv
// Banked register file with current and saved status words. Requests are
// taken one at a time: each is accepted, executed once the response register
// is free and its response registered. A status write (or a saved-to-current
// copy outside user and system modes) that names a valid mode also exchanges
// the banked registers through the banked store one slot per cycle, bounded
// by that store's single write port: 2 slots (r13, r14) in general, 7 slots
// when the fast-interrupt bank is left or entered. The response register lets
// a new request be accepted while a response still waits. Both register
// memories read zero until written, so no clearing pass is needed after reset;
// core_kind is to be written only while idle, a rule left to the user.
module banked_register_file_psr
    import brf_pkg::*;
#(
    parameter int NUM_BANKS = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [2:0]        op,
    input  logic [3:0]        reg_index,
    input  logic [DATA_W-1:0] value,
    input  logic [2:0]        spsr_bank,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [DATA_W-1:0] read_data,
    output logic              flush_request,
    output logic              bad_mode
);

    localparam int BANK_W      = $clog2(NUM_BANKS);
    localparam int STORE_DEPTH = NUM_BANKS * SLOTS_PER_BANK;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int VIS_AW      = $clog2(NUM_REGS);

    function automatic logic bank_fits(logic [2:0] b);
        return {1'b0, b} < 4'(NUM_BANKS);
    endfunction

    state_t            state_reg, state_next;

    op_t               cap_op_reg;
    logic [3:0]        cap_idx_reg;
    logic [DATA_W-1:0] cap_value_reg;
    logic [2:0]        cap_sb_reg;

    logic [4:0]        mode_reg, mode_next;
    logic              thumb_reg, thumb_next;
    logic [6:0]        flags_reg, flags_next;
    logic              core_kind_reg, core_kind_next;
    logic [DATA_W-1:0] saved_reg [NUM_BANKS];
    logic [DATA_W-1:0] saved_next [NUM_BANKS];

    logic [2:0]        slot_reg, slot_next;
    logic [BANK_W-1:0] old_bank_reg, old_bank_next;
    logic [BANK_W-1:0] new_bank_reg, new_bank_next;
    logic              same_bank_reg, same_bank_next;
    logic              wr_valid_reg, wr_valid_next;
    logic [2:0]        wr_slot_reg, wr_slot_next;
    logic              res_flush_reg, res_flush_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0] read_data_reg, read_data_next;
    logic              flush_reg, flush_next;
    logic              bad_reg, bad_next;

    logic              accept;
    logic              out_free;
    logic              exec_fire;
    logic              swap_start;
    logic              fin_fire;

    bank_sel_t         cur_sel;
    logic              cur_ok;
    logic [BANK_W-1:0] cur_bank;
    logic              cb_pos;
    logic [DATA_W-1:0] status_now;
    logic [DATA_W-1:0] spsr_mask;
    logic [DATA_W-1:0] cur_saved;
    logic [DATA_W-1:0] wsrc;
    bank_sel_t         new_sel;
    logic              new_ok;
    logic [BANK_W-1:0] new_bank;
    logic              is_sw;
    logic              sw_go;
    logic              sw_bad;
    logic              fiq_swap;
    logic              sb_ok;
    logic [DATA_W-1:0] spsr_rd;
    logic [DATA_W-1:0] res_data;
    logic              res_flush;

    logic                vis_we;
    logic [VIS_AW-1:0]   vis_waddr;
    logic [DATA_W-1:0]   vis_wdata;
    logic [VIS_AW-1:0]   vis_raddr;
    logic [DATA_W-1:0]   vis_rdata;
    logic                store_we;
    logic [STORE_AW-1:0] store_waddr;
    logic [STORE_AW-1:0] store_raddr;
    logic [DATA_W-1:0]   store_rdata;

    // Visible registers r0-r15
    brf_ram #(.DEPTH(NUM_REGS)) u_vis_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    // Banked copies, eight slots per bank
    brf_ram #(.DEPTH(STORE_DEPTH)) u_store_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (vis_rdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Decode current status and the pending request
    always_comb
    begin
        cur_sel    = bank_of(mode_reg);
        cur_ok     = cur_sel.ok && bank_fits(cur_sel.idx);
        cur_bank   = cur_ok ? cur_sel.idx[BANK_W-1:0] : '0;
        cb_pos     = cur_ok && (cur_sel.idx != BANK_USR);
        status_now = status_word(mode_reg, thumb_reg, flags_reg, core_kind_reg);
        spsr_mask  = core_kind_reg ? SPSR_MASK_NEW : SPSR_MASK_OLD;
        cur_saved  = saved_reg[cur_bank];

        wsrc     = (cap_op_reg == OP_SPSR_TO_CPSR) ? cur_saved : cap_value_reg;
        new_sel  = bank_of(wsrc[4:0]);
        new_ok   = new_sel.ok && bank_fits(new_sel.idx);
        new_bank = new_sel.idx[BANK_W-1:0];
        is_sw    = (cap_op_reg == OP_WRCPSR) || ((cap_op_reg == OP_SPSR_TO_CPSR) && cb_pos);
        sw_go    = is_sw && new_ok;
        sw_bad   = is_sw && !new_ok;
        fiq_swap = (new_sel.idx == BANK_FIQ) || (3'(cur_bank) == BANK_FIQ);

        sb_ok = bank_fits(cap_sb_reg);
        if (cap_sb_reg == BANK_USR)
        begin
            spsr_rd = status_now;
        end
        else if (sb_ok)
        begin
            spsr_rd = saved_reg[cap_sb_reg[BANK_W-1:0]];
        end
        else
        begin
            spsr_rd = '0;
        end

        case (cap_op_reg)
            OP_RDREG:  res_data = vis_rdata;
            OP_RDCPSR: res_data = status_now;
            OP_RDSPSR: res_data = spsr_rd;
            default:   res_data = '0;
        endcase
        res_flush = (cap_op_reg == OP_WRREG) && (cap_idx_reg == REG_PC);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sw_go)
                begin
                    state_next = ST_SWAP;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWAP:
            begin
                if (slot_reg == SLOT_R14)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs and memory port selection
    always_comb
    begin
        req_stall  = (state_reg != ST_IDLE);
        accept     = (state_reg == ST_IDLE) && req_valid;
        out_free   = !rsp_valid_reg || !rsp_stall;
        exec_fire  = (state_reg == ST_EXEC) && !sw_go && out_free;
        swap_start = (state_reg == ST_EXEC) && sw_go;
        fin_fire   = (state_reg == ST_FIN) && out_free;

        case (state_reg)
            ST_IDLE: vis_raddr = reg_index;
            ST_SWAP: vis_raddr = slot_to_reg(slot_reg);
            default: vis_raddr = cap_idx_reg;
        endcase

        vis_we = wr_valid_reg || (exec_fire && (cap_op_reg == OP_WRREG));
        if (wr_valid_reg)
        begin
            vis_waddr = slot_to_reg(wr_slot_reg);
            vis_wdata = same_bank_reg ? vis_rdata : store_rdata;
        end
        else
        begin
            vis_waddr = cap_idx_reg;
            vis_wdata = cap_value_reg;
        end

        store_we    = wr_valid_reg;
        store_waddr = {old_bank_reg, wr_slot_reg};
        store_raddr = {new_bank_reg, slot_reg};
    end

    // Status, saved status and swap sequencing
    always_comb
    begin
        mode_next      = mode_reg;
        thumb_next     = thumb_reg;
        flags_next     = flags_reg;
        core_kind_next = cfg_write_en ? cfg_write_data : core_kind_reg;
        saved_next     = saved_reg;
        slot_next      = slot_reg;
        old_bank_next  = old_bank_reg;
        new_bank_next  = new_bank_reg;
        same_bank_next = same_bank_reg;
        wr_valid_next  = 1'b0;
        wr_slot_next   = wr_slot_reg;
        res_flush_next = res_flush_reg;

        // Commit a valid status write and start the exchange
        if (swap_start)
        begin
            mode_next      = wsrc[4:0];
            thumb_next     = wsrc[5];
            flags_next     = {wsrc[31:27], wsrc[7:6]};
            res_flush_next = (wsrc[5] != thumb_reg);
            old_bank_next  = cur_bank;
            new_bank_next  = new_bank;
            same_bank_next = (cur_bank == new_bank);
            slot_next      = fiq_swap ? SLOT_R8 : SLOT_R13;
        end

        // Advance one slot: read now, write back next cycle
        if (state_reg == ST_SWAP)
        begin
            wr_valid_next = 1'b1;
            wr_slot_next  = slot_reg;
            slot_next     = (slot_reg == SLOT_R12) ? SLOT_R13 : slot_reg + 3'd1;
        end

        // Saved status updates
        if (exec_fire)
        begin
            if ((cap_op_reg == OP_WRSPSR) && (cap_sb_reg != BANK_USR) && sb_ok)
            begin
                saved_next[cap_sb_reg[BANK_W-1:0]] = cap_value_reg & spsr_mask;
            end
            if ((cap_op_reg == OP_CPSR_TO_SPSR) && cb_pos)
            begin
                saved_next[cur_bank] = status_now & spsr_mask;
            end
        end
    end

    // Response register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        read_data_next = read_data_reg;
        flush_next     = flush_reg;
        bad_next       = bad_reg;
        if (exec_fire)
        begin
            rsp_valid_next = 1'b1;
            read_data_next = res_data;
            flush_next     = res_flush;
            bad_next       = sw_bad;
        end
        else if (fin_fire)
        begin
            rsp_valid_next = 1'b1;
            read_data_next = '0;
            flush_next     = res_flush_reg;
            bad_next       = 1'b0;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_USR;
            thumb_reg     <= 1'b0;
            flags_reg     <= '0;
            core_kind_reg <= 1'b0;
            for (int i = 0; i < NUM_BANKS; i++)
            begin
                saved_reg[i] <= '0;
            end
            wr_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            thumb_reg     <= thumb_next;
            flags_reg     <= flags_next;
            core_kind_reg <= core_kind_next;
            saved_reg     <= saved_next;
            wr_valid_reg  <= wr_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request capture, swap bookkeeping and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cap_op_reg    <= op_t'(op);
            cap_idx_reg   <= reg_index;
            cap_value_reg <= value;
            cap_sb_reg    <= spsr_bank;
        end
        slot_reg      <= slot_next;
        old_bank_reg  <= old_bank_next;
        new_bank_reg  <= new_bank_next;
        same_bank_reg <= same_bank_next;
        wr_slot_reg   <= wr_slot_next;
        res_flush_reg <= res_flush_next;
        read_data_reg <= read_data_next;
        flush_reg     <= flush_next;
        bad_reg       <= bad_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign read_data     = read_data_reg;
    assign flush_request = flush_reg;
    assign bad_mode      = bad_reg;

    // The current mode always names a usable bank
    assert property (@(posedge clk) disable iff (!rst_n) cur_ok)
        else $error("mode register holds an unbanked mode");

    // Bank write-back only happens during the exchange or in the finish state after it
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> (state_reg == ST_SWAP) || (state_reg == ST_FIN))
        else $error("bank write-back outside exchange");

    // A rejected mode never also flushes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(bad_reg && flush_reg))
        else $error("response flags both bad mode and flush");

    // A non-zero read result carries no side-effect flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (read_data_reg != '0)) |-> (!flush_reg && !bad_reg))
        else $error("read response carries write flags");

endmodule

>>> sv/brf_ram.sv
module brf_ram
    import brf_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic              hit_reg;
    logic              hit_next;
    logic [DATA_W-1:0] rdata_reg;

    // Mark written entries; unwritten ones read as zero
    always_comb
    begin
        valid_next = valid_reg;
        if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    assign hit_next = valid_reg[raddr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
        hit_reg   <= hit_next;
    end

    assign rdata = hit_reg ? rdata_reg : '0;

endmodule
